### hdl/fsrm_pkg.sv
// Shared types and constants of the frame stall and rate monitor.
package fsrm_pkg;

    // Field widths of the stream channels and the configuration register.
    localparam int TIME_W    = 48;
    localparam int STALL_W   = 32;
    localparam int FRAMES_W  = 10;
    localparam int FPS_W     = 15;
    localparam int CFG_W     = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    // Expected frame rate after reset.
    localparam logic [CFG_W-1:0] CFG_FPS_RESET = 8'd30;

    // Stall threshold numerator; gap > floor(N / fps) is the same as gap * fps > N.
    localparam int                   GAP_NARROW_W    = 11;
    localparam logic [GAP_NARROW_W+CFG_W-1:0] STALL_NUMERATOR = 19'd1500;

    // Rate output is the occupancy over five, in Q8.
    localparam int FPS_DIVISOR = 5;
    localparam int REM_IDX_W   = 3;
    localparam int FRAC_W      = 8;
    localparam logic [FRAC_W-1:0] FPS_FRAC [FPS_DIVISOR] = '{
        8'd0, 8'd51, 8'd102, 8'd153, 8'd204
    };

    // Kind of input transfer.
    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    // Operands of the shared adder and comparator.
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              carry_in;
        logic [TIME_W-1:0] bound;
    } alu_req_t;

    // Results of the shared adder and comparator.
    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              sum_le_bound;
    } alu_rsp_t;

endpackage

### hdl/fsrm_alu.sv
// Shared 49-bit adder with an unsigned compare of the full sum against a bound.
module fsrm_alu
    import fsrm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [TIME_W:0] sum_full;

    // The sum keeps its carry so that times near the top of the range never wrap.
    assign sum_full = {1'b0, req.a} + {1'b0, req.b} + {{TIME_W{1'b0}}, req.carry_in};

    assign rsp.sum          = sum_full[TIME_W-1:0];
    assign rsp.sum_le_bound = (sum_full <= {1'b0, req.bound});

endmodule

### hdl/fsrm_window_ram.sv
// Frame time store with one write port and one registered read port.
module fsrm_window_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 48
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/fsrm_rate_calc.sv
// Occupancy over five in Q8, by a reciprocal multiply with one correction step.
module fsrm_rate_calc
    import fsrm_pkg::*;
#(
    parameter int COUNT_W = 10
) (
    input  logic [COUNT_W-1:0] count,
    output logic [FPS_W-1:0]   fps_q8
);

    localparam int SHIFT  = COUNT_W + 3;
    localparam int PROD_W = COUNT_W + SHIFT;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'((2 ** SHIFT) / FPS_DIVISOR);

    logic [PROD_W-1:0]       prod;
    logic [COUNT_W-1:0]      quot_est;
    logic [COUNT_W+2:0]      five_quot;
    logic [COUNT_W+2:0]      rem_wide;
    logic [3:0]              rem_est;
    logic                    fix;
    logic [COUNT_W-1:0]      quot;
    logic [3:0]              rem_fixed;
    logic [REM_IDX_W-1:0]    rem_idx;
    logic [COUNT_W+FRAC_W:0] fps_full;

    // The estimate is the true quotient or one less.
    assign prod      = PROD_W'(count) * PROD_W'(RECIP);
    assign quot_est  = prod[PROD_W-1:SHIFT];
    assign five_quot = {quot_est, 2'b00} + (COUNT_W+3)'(quot_est);
    assign rem_wide  = (COUNT_W+3)'(count) - five_quot;
    assign rem_est   = rem_wide[3:0];

    // Correct the estimate when the remainder reaches the divisor.
    assign fix       = (rem_est >= 4'(FPS_DIVISOR));
    assign quot      = quot_est + COUNT_W'(fix);
    assign rem_fixed = fix ? (rem_est - 4'(FPS_DIVISOR)) : rem_est;
    assign rem_idx   = rem_fixed[REM_IDX_W-1:0];

    // Whole part shifted into Q8 plus the fraction of the remainder.
    assign fps_full = {1'b0, quot, {FRAC_W{1'b0}}} + (COUNT_W+FRAC_W+1)'(FPS_FRAC[rem_idx]);
    assign fps_q8   = FPS_W'(fps_full);

endmodule

### hdl/frame_stall_and_rate_monitor.sv
// Top level: sequencer around the shared adder, the frame time store and the rate divider.
//
//  Channel    Direction  Handshake                     Contents
//  s_axis     in         s_axis_tvalid/s_axis_tready   tdata: time_ms; tuser: opcode
//  m_axis     out        m_axis_tvalid/m_axis_tready   tdata: stall_count, frames_in_window,
//                                                      render_fps_q8
//  cfg        in         cfg_we                        cfg_wdata: expected_fps
//
// A frame passes the gap subtraction, then the stall count and push, then the eviction
// loop and the result. A query goes to the eviction loop, after a lookup of the newest
// entry when its time is zero; with the window empty it goes straight to the result.
// Each eviction is one read of the store's single read port and one shared-adder compare.
// Reset is synchronous and active low; the store needs no clearing pass, since only
// written entries are ever read. A stalled result is held in the output register, and
// the next item is accepted while it waits.
module frame_stall_and_rate_monitor
    import fsrm_pkg::*;
#(
    parameter int WINDOW_DEPTH     = 512,
    parameter int WINDOW_LENGTH_MS = 5000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,      // expected_fps
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [47:0] time_ms
    input  logic                 s_axis_tuser,   // [0] opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [31:0] stall_count,
                                                 // [41:32] frames_in_window,
                                                 // [56:42] render_fps_q8, [63:57] zero
);

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(WINDOW_DEPTH);
    localparam logic [TIME_W-1:0]  WINDOW_LEN = TIME_W'(WINDOW_LENGTH_MS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_STALL,
        ST_NEWEST,
        ST_NEWEST_WAIT,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [TIME_W-1:0]      gap_reg, gap_next;
    logic [TIME_W-1:0]      last_time_reg, last_time_next;
    logic                   have_last_reg, have_last_next;
    logic [STALL_W-1:0]     stalls_reg, stalls_next;
    logic [ADDR_W-1:0]      head_reg, head_next;
    logic [ADDR_W-1:0]      tail_reg, tail_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [CFG_W-1:0]       fps_cfg_reg, fps_cfg_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [TIME_W-1:0]      ram_rdata;
    logic [FPS_W-1:0]       fps_q8;

    logic [ADDR_W-1:0]      head_inc;
    logic [ADDR_W-1:0]      tail_inc;
    logic [ADDR_W-1:0]      newest_addr;
    logic [GAP_NARROW_W+CFG_W-1:0] gap_prod;
    logic                   gap_over;
    logic                   stall_hit;
    logic                   s_fire;

    // Ring pointer arithmetic for any depth.
    assign head_inc    = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
    assign tail_inc    = (tail_reg == LAST_ADDR) ? '0 : tail_reg + 1'b1;
    assign newest_addr = (tail_reg == '0) ? LAST_ADDR : tail_reg - 1'b1;

    // Stall test: gap > floor(1500 / fps) is gap * fps > 1500.
    assign gap_prod  = (GAP_NARROW_W+CFG_W)'(gap_reg[GAP_NARROW_W-1:0])
                     * (GAP_NARROW_W+CFG_W)'(fps_cfg_reg);
    assign gap_over  = (|gap_reg[TIME_W-1:GAP_NARROW_W]) || (gap_prod > STALL_NUMERATOR);
    assign stall_hit = have_last_reg && (fps_cfg_reg != '0) && gap_over
                     && (stalls_reg != '1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Shared adder operands: the gap subtraction or the eviction test.
    always_comb begin
        if (state_reg == ST_GAP) begin
            alu_req.a        = time_reg;
            alu_req.b        = ~last_time_reg;
            alu_req.carry_in = 1'b1;
            alu_req.bound    = '0;
        end else begin
            alu_req.a        = ram_rdata;
            alu_req.b        = WINDOW_LEN;
            alu_req.carry_in = 1'b0;
            alu_req.bound    = now_reg;
        end
    end

    // Store write on the push step; reads go to the head except for the newest lookup.
    assign ram_we    = (state_reg == ST_STALL);
    assign ram_raddr = (state_reg == ST_NEWEST) ? newest_addr : head_reg;

    // Sequencer and datapath next values.
    always_comb begin
        state_next     = state_reg;
        time_next      = time_reg;
        now_next       = now_reg;
        gap_next       = gap_reg;
        last_time_next = last_time_reg;
        have_last_next = have_last_reg;
        stalls_next    = stalls_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        fps_cfg_next   = cfg_we ? cfg_wdata : fps_cfg_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    time_next = s_axis_tdata;
                    now_next  = s_axis_tdata;
                    if (opcode_t'(s_axis_tuser) == OP_FRAME) begin
                        state_next = ST_GAP;
                    end else if (count_reg == '0) begin
                        state_next = ST_DONE;
                    end else if (s_axis_tdata == '0) begin
                        state_next = ST_NEWEST;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_GAP: begin
                gap_next   = alu_rsp.sum;
                state_next = ST_STALL;
            end
            ST_STALL: begin
                // Count the stall, then push the frame, dropping the oldest when full.
                if (stall_hit) begin
                    stalls_next = stalls_reg + 1'b1;
                end
                last_time_next = time_reg;
                have_last_next = 1'b1;
                tail_next      = tail_inc;
                if (count_reg == FULL_COUNT) begin
                    head_next = head_inc;
                end else begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_READ;
            end
            ST_NEWEST: begin
                state_next = ST_NEWEST_WAIT;
            end
            ST_NEWEST_WAIT: begin
                now_next   = ram_rdata;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // Drop the oldest entry while it has left the window.
                if (alu_rsp.sum_le_bound) begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = (count_reg == COUNT_W'(1)) ? ST_DONE : ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_TDATA_W-STALL_W-FRAMES_W-FPS_W){1'b0}},
                                    fps_q8, FRAMES_W'(count_reg), stalls_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_last_reg <= 1'b0;
            stalls_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fps_cfg_reg   <= CFG_FPS_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_last_reg <= have_last_next;
            stalls_reg    <= stalls_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fps_cfg_reg   <= fps_cfg_next;
            m_valid_reg   <= m_valid_next;
        end
        time_reg      <= time_next;
        now_reg       <= now_next;
        gap_reg       <= gap_next;
        last_time_reg <= last_time_next;
        m_data_reg    <= m_data_next;
    end

    fsrm_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fsrm_window_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (TIME_W)
    ) u_window_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data (time_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    fsrm_rate_calc #(
        .COUNT_W (COUNT_W)
    ) u_rate_calc (
        .count  (count_reg),
        .fps_q8 (fps_q8)
    );

endmodule

### hdl/fsrm_checker.sv
// Port-level checks of the frame stall and rate monitor, bound to the top level.
module fsrm_checker
    import fsrm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 512
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam logic FRAMES_EXACT = (WINDOW_DEPTH < 1024);

    logic [17:0] five_fps;
    logic [17:0] frames_q8;

    assign five_fps  = {1'b0, m_axis_tdata[56:42], 2'b00} + 18'(m_axis_tdata[56:42]);
    assign frames_q8 = {m_axis_tdata[41:32], 8'b0};

    // No result is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One item at a time: the input closes after each accepted transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // The rate is the occupancy over five in Q8, rounded down.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && FRAMES_EXACT |->
            (five_fps <= frames_q8) && (five_fps + 18'd5 > frames_q8))
        else $error("rate does not match occupancy");

    // Occupancy never exceeds the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && FRAMES_EXACT |-> m_axis_tdata[41:32] <= 10'(WINDOW_DEPTH))
        else $error("occupancy above depth");

endmodule

bind frame_stall_and_rate_monitor fsrm_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_fsrm_checker (.*);
